// ----- rtl/nalfr_pkg.sv -----
`default_nettype none
package nalfr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned HEAD_BYTES  = 4;

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [7:0] NAL_TYPE_SEI  = 8'd6;
  localparam logic [7:0] NAL_TYPE_SPS  = 8'd7;
  localparam logic [7:0] NAL_TYPE_PPS  = 8'd8;
  localparam logic [7:0] NAL_TYPE_LO   = 8'd14;
  localparam logic [7:0] NAL_TYPE_HI   = 8'd18;
  localparam logic [7:0] ESC_BYTE      = 8'h03;
  localparam logic [7:0] SC_ONE        = 8'h01;

  // Work request from the front to the back
  typedef enum logic [1:0] {
    CMD_RAW,      // emit data[0..count-1] as is
    CMD_PAYLOAD,  // one payload byte, with escape check
    CMD_FRAME     // start code, header, then escaped data[1..count-1]
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [3:0][7:0] data;
    logic [2:0]      count;
    logic            long_sc;
    logic            unit_end;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREFIX,
    BK_HEAD,
    BK_BODY,
    BK_RAW
  } back_state_t;

  function automatic logic needs_long_sc(input logic [7:0] hdr, input logic frame_first);
    logic [7:0] t;
    t = hdr & NAL_TYPE_MASK;
    return frame_first || (t == NAL_TYPE_SEI) || (t == NAL_TYPE_SPS) ||
           (t == NAL_TYPE_PPS) || ((t >= NAL_TYPE_LO) && (t <= NAL_TYPE_HI));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/nal_to_annexb_framer.sv -----
`default_nettype none
// Turns H.264 NAL unit bytes into an Annex B byte stream. The front end takes one
// input byte per cycle, holds each unit's first four bytes and decides between
// pass-through (unit already starts with 00 00 00 01) and framing with a 3- or
// 4-byte start code; it posts one request per byte that produces output into a
// QUEUE_DEPTH-entry queue. The back end emits one output byte per cycle while it has
// requests lined up and the receiver is ready, adding start codes and 03 escape bytes.
// When the back end has run idle it pops the next request in its idle state, which
// emits nothing. Bytes that produce nothing (first bytes of a unit, bytes outside a
// unit) post no request. The input stalls only while the queue is full.
module nal_to_annexb_framer #(
  parameter int unsigned QUEUE_DEPTH = nalfr_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] nal_byte
  input  wire logic       s_tlast,   // unit_end
  input  wire logic [1:0] s_tuser,   // [0] unit_start, [1] frame_start
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // unit_done
  output logic [0:0]      m_tuser    // [0] run_last
);

  nalfr_pkg::cmd_t push_cmd, pop_cmd;
  logic            push, pop, q_full, q_empty;

  nalfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .nal_byte    (s_tdata),
    .unit_start  (s_tuser[0]),
    .unit_end    (s_tlast),
    .frame_start (s_tuser[1]),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  nalfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_cmd),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .rd_data (pop_cmd)
  );

  nalfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .run_last  (m_tuser[0]),
    .unit_done (m_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/nalfr_front.sv -----
`default_nettype none
module nalfr_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       nal_byte,
  input  wire logic             unit_start,
  input  wire logic             unit_end,
  input  wire logic             frame_start,
  input  wire logic             q_full,
  output logic                  push,
  output nalfr_pkg::cmd_t       cmd
);

  logic [3:0][7:0] head_buffer, head_buffer_next;
  logic [1:0]      head_count, head_count_next;
  logic            pass_through, pass_through_next;
  logic            in_payload, in_payload_next;
  logic            long_sc, long_sc_next;
  logic            accept;
  logic            is_start_code;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    head_buffer_next  = head_buffer;
    head_count_next   = head_count;
    pass_through_next = pass_through;
    in_payload_next   = in_payload;
    long_sc_next      = long_sc;
    push              = 1'b0;
    cmd.kind          = nalfr_pkg::CMD_RAW;
    cmd.data          = head_buffer;
    cmd.count         = 3'd1;
    cmd.long_sc       = long_sc;
    cmd.unit_end      = unit_end;
    is_start_code     = 1'b0;
    if (accept) begin
      priority if (unit_start) begin
        // a new unit drops whatever the open one still holds
        head_buffer_next[0] = nal_byte;
        head_count_next     = 2'd1;
        in_payload_next     = 1'b0;
        pass_through_next   = 1'b0;
        long_sc_next        = nalfr_pkg::needs_long_sc(nal_byte, frame_start);
        if (unit_end) begin
          push            = 1'b1;
          cmd.kind        = nalfr_pkg::CMD_FRAME;
          cmd.data        = head_buffer_next;
          cmd.long_sc     = long_sc_next;
          head_count_next = 2'd0;
        end
      end else if (in_payload) begin
        push        = 1'b1;
        cmd.kind    = pass_through ? nalfr_pkg::CMD_RAW : nalfr_pkg::CMD_PAYLOAD;
        cmd.data[0] = nal_byte;
        if (unit_end) begin
          in_payload_next   = 1'b0;
          pass_through_next = 1'b0;
        end
      end else if (head_count != 2'd0) begin
        head_buffer_next[head_count] = nal_byte;
        cmd.data = head_buffer_next;
        if (head_count == 2'd3) begin
          is_start_code = (head_buffer_next[0] == 8'h00) &&
                          (head_buffer_next[1] == 8'h00) &&
                          (head_buffer_next[2] == 8'h00) &&
                          (head_buffer_next[3] == nalfr_pkg::SC_ONE);
          push              = 1'b1;
          cmd.kind          = is_start_code ? nalfr_pkg::CMD_RAW : nalfr_pkg::CMD_FRAME;
          cmd.count         = 3'd4;
          head_count_next   = 2'd0;
          in_payload_next   = !unit_end;
          pass_through_next = is_start_code && !unit_end;
        end else if (unit_end) begin
          // short unit: flush what is held
          push            = 1'b1;
          cmd.kind        = nalfr_pkg::CMD_FRAME;
          cmd.count       = {1'b0, head_count} + 3'd1;
          head_count_next = 2'd0;
        end else begin
          head_count_next = head_count + 2'd1;
        end
      end else begin
        // no unit open: drop the byte
        push = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_buffer <= head_buffer_next;
    if (rst) begin
      head_count   <= 2'd0;
      pass_through <= 1'b0;
      in_payload   <= 1'b0;
      long_sc      <= 1'b0;
    end else begin
      head_count   <= head_count_next;
      pass_through <= pass_through_next;
      in_payload   <= in_payload_next;
      long_sc      <= long_sc_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/nalfr_queue.sv -----
`default_nettype none
module nalfr_queue #(
  parameter int unsigned DEPTH = nalfr_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire nalfr_pkg::cmd_t wr_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output nalfr_pkg::cmd_t      rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  nalfr_pkg::cmd_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/nalfr_back.sv -----
`default_nettype none
module nalfr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire nalfr_pkg::cmd_t q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 unit_done
);

  nalfr_pkg::back_state_t state, state_next, start_state;
  nalfr_pkg::cmd_t        cur;
  logic [1:0] idx, idx_next;
  logic [1:0] pcnt, pcnt_next;
  logic       esc, esc_next;
  logic [1:0] zero_run, zero_run_next;
  logic       advance;
  logic       emit, e_last;
  logic [7:0] e_byte, cur_b;
  logic       last_idx, last_pay;

  assign advance  = !out_valid || out_ready;
  assign cur_b    = cur.data[idx];
  assign last_idx = ({1'b0, idx} == (cur.count - 3'd1));
  assign last_pay = cur.unit_end && last_idx;

  always_comb begin
    unique case (q_data.kind)
      nalfr_pkg::CMD_FRAME:   start_state = nalfr_pkg::BK_PREFIX;
      nalfr_pkg::CMD_PAYLOAD: start_state = nalfr_pkg::BK_BODY;
      nalfr_pkg::CMD_RAW:     start_state = nalfr_pkg::BK_RAW;
      default:                start_state = nalfr_pkg::BK_IDLE;
    endcase
  end

  // byte datapath
  always_comb begin
    emit          = 1'b0;
    e_last        = 1'b0;
    e_byte        = 8'h00;
    idx_next      = idx;
    pcnt_next     = pcnt;
    esc_next      = esc;
    zero_run_next = zero_run;
    unique case (state)
      nalfr_pkg::BK_PREFIX: begin
        emit      = 1'b1;
        e_byte    = (pcnt == 2'd3) ? nalfr_pkg::SC_ONE : 8'h00;
        pcnt_next = pcnt + 2'd1;
      end
      nalfr_pkg::BK_HEAD: begin
        emit          = 1'b1;
        e_byte        = cur.data[0];
        e_last        = (cur.count == 3'd1);
        zero_run_next = 2'd0;
        idx_next      = 2'd1;
        esc_next      = 1'b0;
      end
      nalfr_pkg::BK_BODY: begin
        emit = 1'b1;
        if ((zero_run == 2'd2) && (cur_b < nalfr_pkg::ESC_BYTE) && !last_pay && !esc) begin
          e_byte        = nalfr_pkg::ESC_BYTE;
          esc_next      = 1'b1;
          zero_run_next = 2'd0;
        end else begin
          e_byte = cur_b;
          e_last = last_idx;
          if (esc || (cur_b != 8'h00)) zero_run_next = 2'd0;
          else if (zero_run != 2'd2)   zero_run_next = zero_run + 2'd1;
          idx_next = idx + 2'd1;
          esc_next = 1'b0;
        end
      end
      nalfr_pkg::BK_RAW: begin
        emit     = 1'b1;
        e_byte   = cur_b;
        e_last   = last_idx;
        idx_next = idx + 2'd1;
      end
      default: emit = 1'b0;
    endcase
    pop = advance && !q_empty && ((state == nalfr_pkg::BK_IDLE) || e_last);
    if (pop) begin
      idx_next  = 2'd0;
      esc_next  = 1'b0;
      pcnt_next = q_data.long_sc ? 2'd0 : 2'd1;
    end
  end

  always_comb begin
    state_next = state;
    if (advance) begin
      unique case (state)
        nalfr_pkg::BK_IDLE:   state_next = pop ? start_state : nalfr_pkg::BK_IDLE;
        nalfr_pkg::BK_PREFIX: if (pcnt == 2'd3) state_next = nalfr_pkg::BK_HEAD;
        nalfr_pkg::BK_HEAD,
        nalfr_pkg::BK_BODY,
        nalfr_pkg::BK_RAW: begin
          if (e_last) state_next = pop ? start_state : nalfr_pkg::BK_IDLE;
          else if (state == nalfr_pkg::BK_HEAD) state_next = nalfr_pkg::BK_BODY;
        end
        default: state_next = nalfr_pkg::BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pop) cur <= q_data;
      idx      <= idx_next;
      pcnt     <= pcnt_next;
      esc      <= esc_next;
      out_byte <= e_byte;
      run_last <= e_last;
      unit_done <= e_last && cur.unit_end;
    end
    if (rst) begin
      state     <= nalfr_pkg::BK_IDLE;
      zero_run  <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        zero_run  <= zero_run_next;
        out_valid <= emit;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/nalfr_checker.sv -----
`default_nettype none
module nalfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic [0:0] m_tuser
);

  logic after_unit;

  // each unit's output after the first since reset opens with a zero byte
  always_ff @(posedge clk) begin
    if (rst) after_unit <= 1'b0;
    else if (m_tvalid && m_tready) after_unit <= m_tlast;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output request changed while stalled");

  a_done_is_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("unit end not on last byte of its run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_unit_opens_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && after_unit |-> m_tdata == 8'h00)
    else $error("unit output does not start with a zero byte");

endmodule

bind nal_to_annexb_framer nalfr_checker u_nalfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int LONG_HOLD  = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       unit_done;
  } framed_byte_t;

  // Tracks the framer state and the Annex B bytes still owed by the block
  class annexb_scoreboard;
    logic [7:0]   head_buf [4];
    int           head_cnt;
    bit           pass_thru;
    bit           long_sc;
    int           zero_cnt;
    bit           in_body;
    framed_byte_t step_q[$];
    framed_byte_t expected_q[$];
    int           errors;
    int           results;
    int           units_closed;
    int           escapes;
    int           pass_units;

    function new();
      head_cnt  = 0;
      pass_thru = 0;
      long_sc   = 0;
      zero_cnt  = 0;
      in_body   = 0;
    endfunction

    function void clear_unit();
      head_cnt  = 0;
      in_body   = 0;
      pass_thru = 0;
      zero_cnt  = 0;
    endfunction

    function void emit(logic [7:0] b);
      framed_byte_t fb;
      if (step_q.size() >= 12) return;
      fb.data      = b;
      fb.run_last  = 1'b0;
      fb.unit_done = 1'b0;
      step_q.push_back(fb);
    endfunction

    function void body_byte(logic [7:0] b, bit last);
      if (zero_cnt >= 2 && b < nalfr_pkg::ESC_BYTE && !last) begin
        emit(nalfr_pkg::ESC_BYTE);
        emit(b);
        zero_cnt = 0;
        escapes++;
        return;
      end
      emit(b);
      if (b == 8'h00) begin
        if (zero_cnt < 2) zero_cnt++;
      end else begin
        zero_cnt = 0;
      end
    endfunction

    function void frame_head(int cnt, bit last);
      if (long_sc) emit(8'h00);
      emit(8'h00);
      emit(8'h00);
      emit(nalfr_pkg::SC_ONE);
      emit(head_buf[0]);
      zero_cnt = 0;
      for (int i = 1; i < cnt && i < 4; i++)
        body_byte(head_buf[i], last && (i + 1 == cnt));
    endfunction

    function void note_input(logic [7:0] b, bit s, bit e, bit f);
      logic [7:0]   t;
      framed_byte_t tail;
      step_q.delete();
      if (s) begin
        t = b & nalfr_pkg::NAL_TYPE_MASK;
        clear_unit();
        long_sc = f || t == nalfr_pkg::NAL_TYPE_SEI || t == nalfr_pkg::NAL_TYPE_SPS ||
                  t == nalfr_pkg::NAL_TYPE_PPS ||
                  (t >= nalfr_pkg::NAL_TYPE_LO && t <= nalfr_pkg::NAL_TYPE_HI);
        head_buf[0] = b;
        head_cnt = 1;
        if (e) frame_head(1, 1'b1);
      end else if (in_body) begin
        if (pass_thru) emit(b);
        else body_byte(b, e);
      end else if (head_cnt >= 1 && head_cnt <= 3) begin
        head_buf[head_cnt] = b;
        head_cnt++;
        if (head_cnt == 4) begin
          if (head_buf[0] == 8'h00 && head_buf[1] == 8'h00 && head_buf[2] == 8'h00 &&
              head_buf[3] == nalfr_pkg::SC_ONE) begin
            pass_thru = 1;
            pass_units++;
            emit(8'h00);
            emit(8'h00);
            emit(8'h00);
            emit(nalfr_pkg::SC_ONE);
          end else begin
            frame_head(4, e);
          end
          head_cnt = 0;
          in_body = 1;
        end else if (e) begin
          frame_head(head_cnt, 1'b1);
        end
      end else begin
        // no unit open: drop the byte
        return;
      end
      if (step_q.size() > 0) begin
        tail = step_q.pop_back();
        tail.run_last = 1'b1;
        if (e) tail.unit_done = 1'b1;
        step_q.push_back(tail);
      end
      if (e) begin
        clear_unit();
        units_closed++;
      end
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void check_result(logic [7:0] b, logic rl, logic ud);
      framed_byte_t want;
      results++;
      if (expected_q.size() == 0) begin
        $error("unexpected output byte %02h (run_last %0b, unit_done %0b)", b, rl, ud);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (b !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, b);
        errors++;
      end
      if (rl !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, rl);
        errors++;
      end
      if (ud !== want.unit_done) begin
        $error("unit_done: expected %0b, got %0b", want.unit_done, ud);
        errors++;
      end
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic [1:0] s_tuser  = 2'b00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [0:0] m_tuser;

  annexb_scoreboard sb = new();

  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         hold_req    = 0;
  int         items       = 0;
  int         idle_cycles = 0;
  logic [7:0] unit_q[$];
  logic [4:0] hot_types [15] = '{5'd1, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd13, 5'd14,
                                 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd0, 5'd31};

  nal_to_annexb_framer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser[0], s_tlast, s_tuser[1]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0], m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input bit s, input bit e, input bit f);
    items++;
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= e;
    s_tuser  <= {f, s};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Send unit_q as one unit; leave it open when close is clear
  task automatic send_unit(input bit frame, input bit close);
    bit e;
    for (int i = 0; i < unit_q.size(); i++) begin
      e = close && (i == unit_q.size() - 1);
      send_item(unit_q[i], i == 0, e, (i == 0) ? frame : bit'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] body_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'h00;
    if (r < 60) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_unit();
    int         kind;
    int         len;
    logic [2:0] ref_bits;
    logic [7:0] hdr;
    kind = $urandom_range(0, 99);
    unit_q.delete();
    // stray byte, lands outside a unit unless the previous one was left open
    if ($urandom_range(0, 99) < 8)
      send_item(8'($urandom_range(0, 255)), 1'b0, bit'($urandom_range(0, 1)),
                bit'($urandom_range(0, 1)));
    if (kind < 15) begin
      unit_q = '{8'h00, 8'h00, 8'h00, nalfr_pkg::SC_ONE};
    end else if (kind < 22) begin
      unit_q = '{8'h00, 8'h00, 8'h00};
      unit_q.push_back(body_value());
    end else begin
      ref_bits = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) hdr = 8'($urandom_range(0, 255));
      else hdr = {ref_bits, hot_types[$urandom_range(0, 14)]};
      unit_q.push_back(hdr);
    end
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 10);
    repeat (len) unit_q.push_back(body_value());
    send_unit($urandom_range(0, 3) == 0, $urandom_range(0, 9) != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-byte units, long and short start code
    unit_q = '{8'h65};
    send_unit(1'b1, 1'b1);
    unit_q = '{8'h41};
    send_unit(1'b0, 1'b1);
    // SPS whose head ends on a 01 that is not a start code
    unit_q = '{8'h67, 8'h00, 8'h00, 8'h01};
    send_unit(1'b0, 1'b1);
    // unit that already carries a start code
    unit_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hff};
    send_unit(1'b0, 1'b1);
    unit_q = '{8'h00, 8'h00};
    send_unit(1'b0, 1'b1);
    unit_q = '{8'hff, 8'hff};
    send_unit(1'b0, 1'b1);
    // escape in the payload
    unit_q = '{8'h41, 8'h00, 8'h00, 8'h02, 8'h05};
    send_unit(1'b0, 1'b1);
    send_item(8'haa, 1'b0, 1'b0, 1'b0);
    // abandon an open unit with a new SEI start
    unit_q = '{8'h61, 8'h12};
    send_unit(1'b0, 1'b0);
    unit_q = '{8'h06};
    send_unit(1'b0, 1'b1);
    wait_drained();

    tx_idle_pct = 33;
    rx_idle_pct = 59;
    while (items < 95) random_unit();
    wait_drained();

    tx_idle_pct = 59;
    rx_idle_pct = 33;
    while (items < 175) random_unit();
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1;
    while (items < 250) random_unit();
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d input bytes, checked %0d output bytes over %0d closed units.",
             items, sb.results, sb.units_closed);
    $display("Escapes inserted: %0d, start-code units passed through: %0d.",
             sb.escapes, sb.pass_units);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
